// ===== design/xy_wormhole_router_switch_assert.svh =====
// Assertion macros for the XY wormhole router switch.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef XY_WORMHOLE_ROUTER_SWITCH_ASSERT_SVH
`define XY_WORMHOLE_ROUTER_SWITCH_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define XYR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define XYR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/xyr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyr_pkg
// Shared types, port codes and helper functions for the XY wormhole router.
// ----------------------------------------------------------------------------
package xyr_pkg;

    localparam int FLIT_WIDTH  = 16;
    localparam int NPORTS      = 5;
    localparam int PORT_W      = 3;
    localparam int COORD_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // Port codes, shared by inputs and outputs
    localparam logic [PORT_W-1:0] PORT_EAST  = 3'd0;
    localparam logic [PORT_W-1:0] PORT_WEST  = 3'd1;
    localparam logic [PORT_W-1:0] PORT_NORTH = 3'd2;
    localparam logic [PORT_W-1:0] PORT_SOUTH = 3'd3;
    localparam logic [PORT_W-1:0] PORT_LOCAL = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_X      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTER_Y      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_CONNECTED = 2'd2;

    localparam logic [NPORTS-1:0] OUT_CONNECTED_RESET = 5'h1F;

    typedef struct packed {
        logic [NPORTS-1:0]     queue_nonempty;
        logic [FLIT_WIDTH-1:0] head_east;
        logic [FLIT_WIDTH-1:0] head_west;
        logic [FLIT_WIDTH-1:0] head_north;
        logic [FLIT_WIDTH-1:0] head_south;
        logic [FLIT_WIDTH-1:0] head_local;
    } item_t;

    typedef struct packed {
        logic                  pop_valid;
        logic [PORT_W-1:0]     pop_port;
        logic                  push_valid;
        logic [PORT_W-1:0]     push_port;
        logic [FLIT_WIDTH-1:0] push_flit;
        logic                  route_error;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] router_x;
        logic [COORD_W-1:0] router_y;
        logic [NPORTS-1:0]  out_connected;
    } cfg_t;

    // Head flit of the given input port
    function automatic logic [FLIT_WIDTH-1:0] head_of(item_t it, logic [PORT_W-1:0] port);
        logic [FLIT_WIDTH-1:0] flit;
        case (port)
            PORT_EAST:  flit = it.head_east;
            PORT_WEST:  flit = it.head_west;
            PORT_NORTH: flit = it.head_north;
            PORT_SOUTH: flit = it.head_south;
            PORT_LOCAL: flit = it.head_local;
            default:    flit = '0;
        endcase
        return flit;
    endfunction

    // Dimension-ordered route: x first, then y
    function automatic logic [PORT_W-1:0] xy_route(cfg_t cfg, logic [FLIT_WIDTH-1:0] flit);
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic [PORT_W-1:0]  port;
        tx = flit[7:4];
        ty = flit[3:0];
        if (cfg.router_x == tx) begin
            if (cfg.router_y == ty)
                port = PORT_LOCAL;
            else if (cfg.router_y > ty)
                port = PORT_SOUTH;
            else
                port = PORT_NORTH;
        end
        else if (cfg.router_x > tx)
            port = PORT_WEST;
        else
            port = PORT_EAST;
        return port;
    endfunction

endpackage

// ===== design/xyr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyr_if
// Valid/ready channel interfaces: input items, results, configuration writes.
// ----------------------------------------------------------------------------
interface xyr_item_if;
    logic          valid;
    logic          ready;
    xyr_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface xyr_result_if;
    logic             valid;
    logic             ready;
    xyr_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface xyr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [xyr_pkg::CFG_INDEX_W-1:0]    index;
    logic [xyr_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== design/xyr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyr_cfg_regs
// Configuration registers: router coordinates and connected-output mask.
// ----------------------------------------------------------------------------
module xyr_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    xyr_cfg_if.sink       cfg,
    output xyr_pkg::cfg_t cfg_val
);

    xyr_pkg::cfg_t cfg_reg;
    xyr_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid) begin
            case (cfg.index)
                xyr_pkg::CFG_ROUTER_X:
                    cfg_next.router_x = cfg.wdata[xyr_pkg::COORD_W-1:0];
                xyr_pkg::CFG_ROUTER_Y:
                    cfg_next.router_y = cfg.wdata[xyr_pkg::COORD_W-1:0];
                xyr_pkg::CFG_OUT_CONNECTED:
                    cfg_next.out_connected = cfg.wdata[xyr_pkg::NPORTS-1:0];
                default:
                    cfg_next = cfg_reg;   // drop writes to unmapped indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.router_x      <= '0;
            cfg_reg.router_y      <= '0;
            cfg_reg.out_connected <= xyr_pkg::OUT_CONNECTED_RESET;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/xyr_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyr_in_stage
// Input register: captures one beat per cycle while ready and holds it until advanced.
// ----------------------------------------------------------------------------
module xyr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    xyr_item_if.sink       item,
    input  logic           advance,
    output logic           hold_valid,
    output xyr_pkg::item_t hold_data
);

    logic           valid_reg;
    logic           valid_next;
    xyr_pkg::item_t data_reg;

    // Take a new beat when empty or when the held beat moves on this cycle
    assign item.ready = !valid_reg || advance;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item.ready)
            valid_next = item.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            data_reg <= item.data;
    end

endmodule

// ===== design/xyr_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyr_engine
// Arbitration / header / length / burst sequencer with XY route selection.
// ----------------------------------------------------------------------------
`include "xy_wormhole_router_switch_assert.svh"

module xyr_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  xyr_pkg::item_t   data,
    input  xyr_pkg::cfg_t    cfg_val,
    output xyr_pkg::result_t res
);

    localparam logic [1:0] PH_ARB    = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_LEN    = 2'd2;
    localparam logic [1:0] PH_BURST  = 2'd3;

    logic [1:0]                      phase_reg;
    logic [1:0]                      phase_next;
    logic [xyr_pkg::PORT_W-1:0]      rr_reg;
    logic [xyr_pkg::PORT_W-1:0]      rr_next;
    logic [xyr_pkg::PORT_W-1:0]      src_reg;
    logic [xyr_pkg::PORT_W-1:0]      src_next;
    logic [xyr_pkg::PORT_W-1:0]      tgt_reg;
    logic [xyr_pkg::PORT_W-1:0]      tgt_next;
    logic [xyr_pkg::FLIT_WIDTH-1:0]  flits_left_reg;
    logic [xyr_pkg::FLIT_WIDTH-1:0]  flits_left_next;

    logic [xyr_pkg::FLIT_WIDTH-1:0]  rr_head;
    logic [xyr_pkg::FLIT_WIDTH-1:0]  src_head;
    logic [xyr_pkg::PORT_W-1:0]      route;

    assign rr_head  = xyr_pkg::head_of(data, rr_reg);
    assign src_head = xyr_pkg::head_of(data, src_reg);
    assign route    = xyr_pkg::xy_route(cfg_val, rr_head);

    always_comb
    begin
        phase_next      = phase_reg;
        rr_next         = rr_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        flits_left_next = flits_left_reg;
        res             = '0;

        case (phase_reg)
            PH_ARB:
            begin
                // Stay on a ready port, otherwise move round-robin
                if (data.queue_nonempty[rr_reg])
                    phase_next = PH_HEADER;
                else if (rr_reg == xyr_pkg::PORT_LOCAL)
                    rr_next = xyr_pkg::PORT_EAST;
                else
                    rr_next = rr_reg + 3'd1;
            end
            PH_HEADER:
            begin
                if (data.queue_nonempty[rr_reg]) begin
                    src_next      = rr_reg;
                    tgt_next      = route;
                    res.pop_valid = 1'b1;
                    res.pop_port  = rr_reg;
                    if (!cfg_val.out_connected[route]) begin
                        // Drop the header and rearbitrate
                        res.route_error = 1'b1;
                        phase_next      = PH_ARB;
                    end
                    else begin
                        res.push_valid = 1'b1;
                        res.push_port  = route;
                        res.push_flit  = rr_head;
                        phase_next     = PH_LEN;
                    end
                end
            end
            PH_LEN:
            begin
                if (data.queue_nonempty[src_reg]) begin
                    flits_left_next = src_head;
                    res.pop_valid   = 1'b1;
                    res.pop_port    = src_reg;
                    res.push_valid  = 1'b1;
                    res.push_port   = tgt_reg;
                    res.push_flit   = src_head;
                    phase_next      = PH_BURST;
                end
            end
            PH_BURST:
            begin
                if (flits_left_reg == '0) begin
                    phase_next = PH_ARB;
                end
                else if (data.queue_nonempty[src_reg]) begin
                    res.pop_valid   = 1'b1;
                    res.pop_port    = src_reg;
                    res.push_valid  = 1'b1;
                    res.push_port   = tgt_reg;
                    res.push_flit   = src_head;
                    flits_left_next = flits_left_reg - (xyr_pkg::FLIT_WIDTH)'(1);
                end
            end
            default:
            begin
                phase_next = PH_ARB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_ARB;
            rr_reg         <= xyr_pkg::PORT_LOCAL;
            src_reg        <= '0;
            tgt_reg        <= '0;
            flits_left_reg <= '0;
        end
        else if (fire) begin
            phase_reg      <= phase_next;
            rr_reg         <= rr_next;
            src_reg        <= src_next;
            tgt_reg        <= tgt_next;
            flits_left_reg <= flits_left_next;
        end
    end

    `XYR_ASSERT_SAME(a_rr_in_range, 1'b1, rr_reg <= xyr_pkg::PORT_LOCAL,
                     "rr pointer out of range")
    `XYR_ASSERT_SAME(a_error_drops, res.route_error, res.pop_valid && !res.push_valid,
                     "route error beat pushed")
    `XYR_ASSERT_NEXT(a_len_loads,
                     fire && phase_reg == PH_LEN && data.queue_nonempty[src_reg],
                     phase_reg == PH_BURST && flits_left_reg == $past(res.push_flit),
                     "length flit not loaded")
    `XYR_ASSERT_NEXT(a_hold_idle, !fire,
                     $stable(phase_reg) && $stable(rr_reg) && $stable(flits_left_reg),
                     "state moved without a beat")

endmodule

// ===== design/xy_wormhole_router_switch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xy_wormhole_router_switch
// Five-port wormhole router switch: round-robin input arbitration, XY route,
// at most one flit moved per beat, with a registered result per input beat.
// ----------------------------------------------------------------------------
//  channel   role   beat carries
//  item      sink   queue_nonempty + five head flits
//  result    source pop / push / route_error decision
//  cfg       sink   register index + write data (always ready)
//
//  One beat accepted per cycle unless the result side stalls; one result per
//  beat. Each result is registered (input register, then result register).
//  rst_n clears the sequencer, the pointer (to local) and both valid flags.
//  A stalled result register holds and backs up into the input register;
//  item.ready drops only when both are full.
// ----------------------------------------------------------------------------
module xy_wormhole_router_switch (
    input  logic        clk,
    input  logic        rst_n,
    xyr_item_if.sink    item,
    xyr_result_if.source result,
    xyr_cfg_if.sink     cfg
);

    xyr_pkg::cfg_t    cfg_val;
    xyr_pkg::item_t   hold_data;
    xyr_pkg::result_t step_res;
    logic             hold_valid;
    logic             advance;

    logic             out_valid_reg;
    logic             out_valid_next;
    xyr_pkg::result_t out_data_reg;

    // Advance the held beat when the result slot is free or being drained
    assign advance = hold_valid && (!out_valid_reg || result.ready);

    xyr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    xyr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    xyr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .data    (hold_data),
        .cfg_val (cfg_val),
        .res     (step_res)
    );

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= step_res;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the XY wormhole router switch. Snapshot beats are
// built from modeled input lanes that carry whole packets, plus some noise.
// A local model of the switch predicts one decision per accepted beat, and
// every result beat is checked in order under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import xyr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_TICKS    = 175;
    localparam int NUM_PHASES     = 8;
    localparam int DRAIN_CYCLES   = 4;

    typedef enum logic [1:0] {SW_ARB, SW_HEADER, SW_LENGTH, SW_BURST} sw_phase_t;

    typedef struct packed {
        sw_phase_t             phase;
        logic [PORT_W-1:0]     pointer;
        logic [PORT_W-1:0]     src;
        logic [PORT_W-1:0]     dst;
        logic [FLIT_WIDTH-1:0] remaining;
    } switch_state_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    xyr_item_if   item_ch ();
    xyr_result_if result_ch ();
    xyr_cfg_if    cfg_ch ();

    xy_wormhole_router_switch dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    cfg_t          sw_cfg;
    cfg_t          plan_cfg;
    switch_state_t sw_state;
    switch_state_t plan_state;

    item_t                 tick_queue [$];
    result_t               expected_decisions [$];
    logic [FLIT_WIDTH-1:0] lane_flits [NPORTS][$];

    int   error_count     = 0;
    int   idle_cycles     = 0;
    int   sender_idle_pct = 0;
    int   sink_stall_pct  = 0;
    logic item_fired      = 1'b0;
    logic cfg_fired       = 1'b0;

    cfg_t phase_cfg [NUM_PHASES] = '{
        '{4'd0,  4'd0,  5'h1F},
        '{4'd15, 4'd15, 5'h1F},
        '{4'd7,  4'd3,  5'h0E},
        '{4'd15, 4'd0,  5'h00},
        '{4'd0,  4'd15, 5'h15},
        '{4'd9,  4'd12, 5'h1F},
        '{4'd3,  4'd8,  5'h1B},
        '{4'd12, 4'd6,  5'h1E}
    };

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // X first, then Y
    function automatic logic [PORT_W-1:0] steer_port(cfg_t c, logic [FLIT_WIDTH-1:0] hdr);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        dx = hdr[7:4];
        dy = hdr[3:0];
        if (dx < c.router_x)
            return PORT_WEST;
        if (dx > c.router_x)
            return PORT_EAST;
        if (dy < c.router_y)
            return PORT_SOUTH;
        if (dy > c.router_y)
            return PORT_NORTH;
        return PORT_LOCAL;
    endfunction

    function automatic void switch_step(input cfg_t c, input item_t it,
                                        inout switch_state_t st, output result_t r);
        logic [FLIT_WIDTH-1:0] heads [NPORTS];
        logic [FLIT_WIDTH-1:0] flit;
        heads = '{it.head_east, it.head_west, it.head_north, it.head_south, it.head_local};
        r = '0;
        case (st.phase)
            SW_ARB:
            begin
                if (it.queue_nonempty[st.pointer])
                    st.phase = SW_HEADER;
                else
                    st.pointer = (st.pointer == PORT_LOCAL) ? PORT_EAST : st.pointer + 3'd1;
            end
            SW_HEADER:
            begin
                if (it.queue_nonempty[st.pointer])
                begin
                    st.src      = st.pointer;
                    flit        = heads[st.src];
                    st.dst      = steer_port(c, flit);
                    r.pop_valid = 1'b1;
                    r.pop_port  = st.src;
                    // drop the header when its output does not exist
                    if (!c.out_connected[st.dst])
                    begin
                        r.route_error = 1'b1;
                        st.phase      = SW_ARB;
                    end
                    else
                    begin
                        r.push_valid = 1'b1;
                        r.push_port  = st.dst;
                        r.push_flit  = flit;
                        st.phase     = SW_LENGTH;
                    end
                end
            end
            SW_LENGTH:
            begin
                if (it.queue_nonempty[st.src])
                begin
                    st.remaining = heads[st.src];
                    r.pop_valid  = 1'b1;
                    r.pop_port   = st.src;
                    r.push_valid = 1'b1;
                    r.push_port  = st.dst;
                    r.push_flit  = heads[st.src];
                    st.phase     = SW_BURST;
                end
            end
            default:
            begin
                if (st.remaining == '0)
                    st.phase = SW_ARB;
                else if (it.queue_nonempty[st.src])
                begin
                    r.pop_valid  = 1'b1;
                    r.pop_port   = st.src;
                    r.push_valid = 1'b1;
                    r.push_port  = st.dst;
                    r.push_flit  = heads[st.src];
                    st.remaining = st.remaining - FLIT_WIDTH'(1);
                end
            end
        endcase
    endfunction

    function automatic void apply_reg(inout cfg_t c, input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ROUTER_X:      c.router_x      = val[COORD_W-1:0];
            CFG_ROUTER_Y:      c.router_y      = val[COORD_W-1:0];
            CFG_OUT_CONNECTED: c.out_connected = val[NPORTS-1:0];
            default:           ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [FLIT_WIDTH-1:0] want,
                                        logic [FLIT_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic item_t snap(logic [NPORTS-1:0] mask, logic [FLIT_WIDTH-1:0] e,
                                   logic [FLIT_WIDTH-1:0] w, logic [FLIT_WIDTH-1:0] n,
                                   logic [FLIT_WIDTH-1:0] s, logic [FLIT_WIDTH-1:0] l);
        item_t it;
        it.queue_nonempty = mask;
        it.head_east      = e;
        it.head_west      = w;
        it.head_north     = n;
        it.head_south     = s;
        it.head_local     = l;
        return it;
    endfunction

    // Advance the planning copy so lane contents follow what the switch pops
    function automatic void queue_tick(item_t it);
        result_t r;
        switch_step(plan_cfg, it, plan_state, r);
        if (r.pop_valid && lane_flits[r.pop_port].size() != 0)
            void'(lane_flits[r.pop_port].pop_front());
        tick_queue.push_back(it);
    endfunction

    task automatic queue_random_tick();
        logic [FLIT_WIDTH-1:0] heads [NPORTS];
        logic [NPORTS-1:0]     mask;
        logic [COORD_W-1:0]    tx;
        logic [COORD_W-1:0]    ty;
        int                    body;
        for (int p = 0; p < NPORTS; p++)
        begin
            if (lane_flits[p].size() == 0 && $urandom_range(3) == 0)
            begin
                tx = COORD_W'($urandom);
                ty = COORD_W'($urandom);
                case ($urandom_range(2))
                    0:
                    begin
                        tx = plan_cfg.router_x;
                        ty = plan_cfg.router_y;
                    end
                    1:       tx = plan_cfg.router_x;
                    default: ;
                endcase
                body = ($urandom_range(5) == 0) ? 0 : $urandom_range(5, 1);
                lane_flits[p].push_back({8'($urandom), tx, ty});
                lane_flits[p].push_back(FLIT_WIDTH'(body));
                repeat (body) lane_flits[p].push_back(FLIT_WIDTH'($urandom));
            end
        end
        if ($urandom_range(9) == 0)
        begin
            mask = NPORTS'($urandom);
            for (int p = 0; p < NPORTS; p++)
                heads[p] = FLIT_WIDTH'($urandom);
        end
        else
        begin
            for (int p = 0; p < NPORTS; p++)
            begin
                mask[p]  = (lane_flits[p].size() != 0) && ($urandom_range(7) != 0);
                heads[p] = (lane_flits[p].size() != 0) ? lane_flits[p][0]
                                                       : FLIT_WIDTH'($urandom);
            end
        end
        // keep bursts short when a stray flit lands in the length slot
        if (plan_state.phase == SW_LENGTH && heads[plan_state.src] > 16'd5)
            heads[plan_state.src] = FLIT_WIDTH'($urandom_range(5));
        queue_tick(snap(mask, heads[PORT_EAST], heads[PORT_WEST], heads[PORT_NORTH],
                        heads[PORT_SOUTH], heads[PORT_LOCAL]));
    endtask

    // Sample at the rising edge, where the driven valid has settled
    task automatic wait_idle();
        while (tick_queue.size() != 0 || item_ch.valid || expected_decisions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Call at a falling edge; returns at the falling edge after the beat
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        apply_reg(plan_cfg, idx, val);
        do
            @(negedge clk);
        while (!cfg_fired);
    endtask

    task automatic configure(cfg_t c);
        write_reg(CFG_ROUTER_X, CFG_DATA_W'(c.router_x));
        write_reg(CFG_ROUTER_Y, CFG_DATA_W'(c.router_y));
        write_reg(CFG_OUT_CONNECTED, CFG_DATA_W'(c.out_connected));
        cfg_ch.valid <= 1'b0;
    endtask

    // Driver: launch and hold item beats, toggle result ready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (!item_ch.valid || item_fired)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    item_ch.data  <= tick_queue.pop_front();
                    item_ch.valid <= 1'b1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Monitor: predict on item beats, check result beats, track config beats
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        logic    result_fired;
        item_fired   = rst_n && item_ch.valid && item_ch.ready;
        cfg_fired    = rst_n && cfg_ch.valid && cfg_ch.ready;
        result_fired = rst_n && result_ch.valid && result_ch.ready;
        if (cfg_fired)
            apply_reg(sw_cfg, cfg_ch.index, cfg_ch.wdata);
        if (item_fired)
        begin
            switch_step(sw_cfg, item_ch.data, sw_state, want);
            expected_decisions.push_back(want);
        end
        if (result_fired)
        begin
            got = result_ch.data;
            if (expected_decisions.size() == 0)
            begin
                $display("%0t: result beat %h with nothing expected", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                check_field("pop_valid", FLIT_WIDTH'(want.pop_valid), FLIT_WIDTH'(got.pop_valid));
                check_field("pop_port", FLIT_WIDTH'(want.pop_port), FLIT_WIDTH'(got.pop_port));
                check_field("push_valid", FLIT_WIDTH'(want.push_valid),
                            FLIT_WIDTH'(got.push_valid));
                check_field("push_port", FLIT_WIDTH'(want.push_port), FLIT_WIDTH'(got.push_port));
                check_field("push_flit", want.push_flit, got.push_flit);
                check_field("route_error", FLIT_WIDTH'(want.route_error),
                            FLIT_WIDTH'(got.route_error));
            end
        end
        if (item_fired || cfg_fired || result_fired)
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("xy_wormhole_router_switch: mismatch");
        $finish;
    end

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.wdata    = '0;
        sw_cfg          = '{router_x: '0, router_y: '0, out_connected: OUT_CONNECTED_RESET};
        plan_cfg        = sw_cfg;
        sw_state        = '{phase: SW_ARB, pointer: PORT_LOCAL, default: '0};
        plan_state      = sw_state;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: south output missing so one header can be dropped
        configure('{4'd5, 4'd5, 5'h17});
        queue_tick(snap(5'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h1F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_tick(snap(5'h1E, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_tick(snap(5'h01, 16'hAB55, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
        queue_tick(snap(5'h00, 16'h0002, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h01, 16'h0002, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
        queue_tick(snap(5'h00, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h01, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h01, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_tick(snap(5'h1F, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555));
        queue_tick(snap(5'h1E, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h02, 16'h0000, 16'h0035, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h02, 16'h0000, 16'h0035, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h02, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0052, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0052, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0052, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0059, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0059, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000));
        queue_tick(snap(5'h04, 16'h0000, 16'h0000, 16'h1234, 16'h0000, 16'h0000));
        queue_tick(snap(5'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_tick(snap(5'h08, 16'h0000, 16'h0000, 16'h0000, 16'h0095, 16'h0000));
        queue_tick(snap(5'h08, 16'h0000, 16'h0000, 16'h0000, 16'h0095, 16'h0000));
        queue_tick(snap(5'h08, 16'h0000, 16'h0000, 16'h0000, 16'h0095, 16'h0000));

        // Random: packet traffic with noise; the packet in flight may span a
        // register change
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            configure(phase_cfg[ph]);
            case (ph % 4)
                0:
                begin
                    sender_idle_pct = 84;
                    sink_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 84;
                end
                2:
                begin
                    sender_idle_pct = 8;
                    sink_stall_pct  = 8;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // hold off mid-phase until every decision has come back
                if (n == PHASE_TICKS / 2)
                    wait_idle();
                queue_random_tick();
            end
        end

        wait_idle();
        if (error_count == 0)
            $display("xy_wormhole_router_switch: match");
        else
            $display("xy_wormhole_router_switch: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/xyr_pkg.sv
design/xyr_if.sv
design/xyr_cfg_regs.sv
design/xyr_in_stage.sv
design/xyr_engine.sv
design/xy_wormhole_router_switch.sv
tb/testbench.sv
